// ===== sv/cspid_pkg.sv =====
// ----------------------------------------------------------------------------
// cspid_pkg
// Types and constants shared by the capture speed PID controller modules.
// ----------------------------------------------------------------------------
package cspid_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic [CfgIdxW-1:0] CFG_TARGET = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KP     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KI     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KD     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALE  = 3'd4;

  localparam logic [15:0] TARGET_RST = 16'd49;
  localparam logic [11:0] KP_RST     = 12'd492;
  localparam logic [11:0] KI_RST     = 12'd26;
  localparam logic [11:0] KD_RST     = 12'd640;
  localparam logic [31:0] SCALE_RST  = 32'd1043440000;

  localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
  localparam logic [14:0] INTEG_MAX   = 15'd25600;
  localparam logic [6:0]  DUTY_MAX    = 7'd100;
  localparam logic [DivCntW-1:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_END,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_P,
    ST_DUTY,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_INTEG,
    MUL_DERIV,
    MUL_PROP
  } mul_sel_e;

  typedef struct packed {
    logic     edge_start;
    logic     tick_start;
    logic     div_step;
    logic     div_end;
    mul_sel_e mul_sel;
    logic     duty_upd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic period_zero;
  } status_t;

endpackage

// ===== sv/cspid_if.sv =====
// ----------------------------------------------------------------------------
// cspid_in_if / cspid_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cspid_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] capture_time;

  modport source (output valid, cmd, capture_time, input ready);
  modport sink (input valid, cmd, capture_time, output ready);
endinterface

interface cspid_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  duty;
  logic [15:0] speed;

  modport source (output valid, duty, speed, input ready);
  modport sink (input valid, duty, speed, output ready);
endinterface

// ===== sv/capture_speed_pid_controller_core.sv =====
// ----------------------------------------------------------------------------
// capture_speed_pid_controller_core
// Motor speed loop: capture-period speed measurement and a PID duty output.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one beat per item: cmd 0 is a capture edge with
// its timer value in capture_time, cmd 1 is a control tick. Every item gives
// exactly one beat on out_ch with the current duty and measured speed.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// (0 target, 1 kp, 2 ki, 3 kd, 4 speed scale); the user must write them only
// while no item is in flight, as the block does not enforce it. For an edge,
// a radix-2 divider computes scale / period; a zero period skips it.
// A tick makes three passes through one shared 13x32 multiplier (integral,
// derivative, proportional) and a duty clamp.
// One item is in flight at a time; in_ch.ready is high only when idle.
// The result sits in an output register: a stalled receiver holds the beat,
// and the next item may be accepted meanwhile, finishing its work and then
// waiting until the held beat is taken.
// Reset loads the register defaults and clears all loop state; no beat is
// pending after reset.
// ----------------------------------------------------------------------------
module capture_speed_pid_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cspid_in_if.sink                        in_ch,
  cspid_out_if.source                     out_ch,
  input  logic                            cfg_we_i,
  input  logic [cspid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cspid_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  cspid_pkg::cmd_t    cmd;
  cspid_pkg::status_t status;
  logic               in_ready;
  logic               out_valid;
  logic [6:0]         duty;
  logic [15:0]        speed;

  cspid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_cmd_i    (in_ch.cmd),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cspid_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .capture_time_i (in_ch.capture_time),
    .cmd_i          (cmd),
    .status_o       (status),
    .duty_o         (duty),
    .speed_o        (speed)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.duty  = duty;
  assign out_ch.speed = speed;

endmodule

// ===== sv/cspid_ctrl.sv =====
// ----------------------------------------------------------------------------
// cspid_ctrl
// Sequencer: input/output handshake, divider count and PID step order.
// ----------------------------------------------------------------------------
module cspid_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_cmd_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  cspid_pkg::status_t          status_i,
  output cspid_pkg::cmd_t             cmd_o
);

  cspid_pkg::state_e                  state_q, state_d;
  logic [cspid_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic                               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cspid_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_sel = cspid_pkg::MUL_NONE;
    unique case (state_q)
      cspid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i) begin
            cmd_o.tick_start = 1'b1;
            state_d = cspid_pkg::ST_MUL_I;
          end else begin
            cmd_o.edge_start = 1'b1;
            cnt_d = '0;
            state_d = status_i.period_zero ? cspid_pkg::ST_OUT : cspid_pkg::ST_DIV;
          end
        end
      end
      cspid_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cspid_pkg::DIV_LAST) begin
          state_d = cspid_pkg::ST_DIV_END;
        end
      end
      cspid_pkg::ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        state_d = cspid_pkg::ST_OUT;
      end
      cspid_pkg::ST_MUL_I: begin
        cmd_o.mul_sel = cspid_pkg::MUL_INTEG;
        state_d = cspid_pkg::ST_MUL_D;
      end
      cspid_pkg::ST_MUL_D: begin
        cmd_o.mul_sel = cspid_pkg::MUL_DERIV;
        state_d = cspid_pkg::ST_MUL_P;
      end
      cspid_pkg::ST_MUL_P: begin
        cmd_o.mul_sel = cspid_pkg::MUL_PROP;
        state_d = cspid_pkg::ST_DUTY;
      end
      cspid_pkg::ST_DUTY: begin
        cmd_o.duty_upd = 1'b1;
        state_d = cspid_pkg::ST_OUT;
      end
      cspid_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = cspid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cspid_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/cspid_dpath.sv =====
// ----------------------------------------------------------------------------
// cspid_dpath
// Configuration registers, loop state, radix-2 divider, shared multiplier
// and the result register.
// ----------------------------------------------------------------------------
module cspid_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cspid_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cspid_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic [31:0]                       capture_time_i,
  input  cspid_pkg::cmd_t                   cmd_i,
  output cspid_pkg::status_t                status_o,
  output logic [6:0]                        duty_o,
  output logic [15:0]                       speed_o
);

  logic [15:0]        target_q;
  logic [11:0]        kp_q, ki_q, kd_q;
  logic [31:0]        scale_q;

  logic [31:0]        last_q;
  logic [15:0]        speed_q, speed_d;
  logic [14:0]        acc_q, acc_d;
  logic signed [16:0] prev_q;
  logic [6:0]         duty_q, duty_d;

  logic [31:0]        period_q;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        quo_q, quo_d;
  logic signed [16:0] err_q;
  logic signed [44:0] prod_q;

  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic signed [30:0] integ_sum;
  logic signed [31:0] pid_sum;
  logic signed [12:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [44:0] mul_p;
  logic [32:0]        rem_sh;
  logic [33:0]        rem_sub;

  assign status_o.period_zero = (capture_time_i == last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= cspid_pkg::TARGET_RST;
      kp_q     <= cspid_pkg::KP_RST;
      ki_q     <= cspid_pkg::KI_RST;
      kd_q     <= cspid_pkg::KD_RST;
      scale_q  <= cspid_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cspid_pkg::CFG_TARGET: target_q <= cfg_wdata_i[15:0];
        cspid_pkg::CFG_KP:     kp_q     <= cfg_wdata_i[11:0];
        cspid_pkg::CFG_KI:     ki_q     <= cfg_wdata_i[11:0];
        cspid_pkg::CFG_KD:     kd_q     <= cfg_wdata_i[11:0];
        cspid_pkg::CFG_SCALE:  scale_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // divider step: restoring, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, period_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.edge_start) begin
      rem_d = '0;
      quo_d = scale_q;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[33]) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  // PID arithmetic
  assign err  = $signed({1'b0, target_q}) - $signed({1'b0, speed_q});
  assign diff = $signed({err_q[16], err_q}) - $signed({prev_q[16], prev_q});
  assign integ_sum = $signed({16'b0, acc_q}) + prod_q[30:0];
  assign pid_sum = $signed({{7{err_q[16]}}, err_q, 8'b0}) + $signed({17'b0, acc_q})
                 + prod_q[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      cspid_pkg::MUL_INTEG: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = $signed({{15{err[16]}}, err});
      end
      cspid_pkg::MUL_DERIV: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = $signed({{14{diff[17]}}, diff});
      end
      cspid_pkg::MUL_PROP: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = pid_sum;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    speed_d = speed_q;
    acc_d   = acc_q;
    duty_d  = duty_q;
    if (cmd_i.edge_start && status_o.period_zero) begin
      speed_d = cspid_pkg::SPEED_MAX;
    end else if (cmd_i.div_end) begin
      speed_d = (|quo_q[31:16]) ? cspid_pkg::SPEED_MAX : quo_q[15:0];
    end
    if (cmd_i.mul_sel == cspid_pkg::MUL_DERIV) begin
      if (integ_sum[30]) begin
        acc_d = '0;
      end else if (integ_sum > $signed({16'b0, cspid_pkg::INTEG_MAX})) begin
        acc_d = cspid_pkg::INTEG_MAX;
      end else begin
        acc_d = integ_sum[14:0];
      end
    end
    if (cmd_i.duty_upd) begin
      if (prod_q <= 45'sd0) begin
        duty_d = '0;
      end else if (prod_q >= 45'sd6553600) begin
        duty_d = cspid_pkg::DUTY_MAX;
      end else begin
        duty_d = prod_q[22:16];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      speed_q <= '0;
      acc_q   <= '0;
      prev_q  <= '0;
      duty_q  <= '0;
    end else begin
      speed_q <= speed_d;
      acc_q   <= acc_d;
      duty_q  <= duty_d;
      if (cmd_i.edge_start) begin
        last_q <= capture_time_i;
      end
      if (cmd_i.duty_upd) begin
        prev_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.edge_start) begin
      period_q <= capture_time_i - last_q;
    end
    if (cmd_i.tick_start) begin
      err_q <= err;
    end
    if (cmd_i.mul_sel != cspid_pkg::MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (cmd_i.out_load) begin
      duty_o  <= duty_q;
      speed_o <= speed_q;
    end
  end

endmodule
